[rtl/owna_pkg.sv]
// Package with the shared types and constants of the overlap-weighted neighbor average block.
`default_nettype none

package owna_pkg;

  // Kind of one contribution transaction.
  typedef enum logic [1:0] {
    KIND_HORIZ_NBR = 2'd0,
    KIND_VERT_NBR  = 2'd1,
    KIND_EMPTY_TB  = 2'd2,
    KIND_EMPTY_LR  = 2'd3
  } kind_t;

  // Width of the border-sum accumulator and of the divider's dividend.
  localparam int unsigned ACC_W = 64;

endpackage

`default_nettype wire

[rtl/owna_if.sv]
// Valid/ready channel interfaces for the contribution input and the average output.
`default_nettype none

interface owna_in_if #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned TEMP_BITS  = 32
) ();
  logic                         valid;
  logic                         ready;
  owna_pkg::kind_t              kind;
  logic        [COORD_BITS-1:0] box_x;
  logic        [COORD_BITS-1:0] box_y;
  logic        [COORD_BITS-1:0] box_width;
  logic        [COORD_BITS-1:0] box_height;
  logic signed [TEMP_BITS-1:0]  box_temp;
  logic        [COORD_BITS-1:0] nbr_x;
  logic        [COORD_BITS-1:0] nbr_y;
  logic        [COORD_BITS-1:0] nbr_width;
  logic        [COORD_BITS-1:0] nbr_height;
  logic signed [TEMP_BITS-1:0]  nbr_temp;
  logic                         last;

  modport source (
    output valid, kind, box_x, box_y, box_width, box_height, box_temp,
           nbr_x, nbr_y, nbr_width, nbr_height, nbr_temp, last,
    input  ready
  );
  modport sink (
    input  valid, kind, box_x, box_y, box_width, box_height, box_temp,
           nbr_x, nbr_y, nbr_width, nbr_height, nbr_temp, last,
    output ready
  );
endinterface

interface owna_out_if #(
  parameter int unsigned TEMP_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [TEMP_BITS-1:0] border_avg;
  logic                        error_flag;

  modport source (output valid, border_avg, error_flag, input ready);
  modport sink   (input valid, border_avg, error_flag, output ready);
endinterface

`default_nettype wire

[rtl/overlap_weighted_neighbor_average_core.sv]
// Overlap-weighted neighbor average: accumulates border contributions and divides by the perimeter.
//
// Usage: in_ch carries one contribution transaction per neighbor or empty side of a cell;
// the transaction with last set closes the cell. out_ch carries one result transaction per
// closed cell: the border sum divided by 2*box_width + 2*box_height, truncated toward zero
// and saturated, with error_flag set for a zero perimeter or a saturated quotient.
// Timing: a contribution passes capture, overlap length, multiply and accumulate in turn,
// set by the single multiplier and accumulator stepped by the sequencer. A closing
// contribution then also finishes the sum and divides; the restoring divider yields one
// quotient bit per cycle over the 64-bit sum, so it sets the latency of each result.
// A zero perimeter skips the divider. in_ch.ready is high only while the sequencer idles.
// The result sits in an output register; a stalled receiver does not block the next
// contributions, but the next cell result waits until the previous one has been taken.
// Reset is synchronous: it clears the accumulator, the sequencer and the output valid.
`default_nettype none

module overlap_weighted_neighbor_average_core #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned TEMP_BITS  = 32
) (
  input wire logic clk,
  input wire logic rst,
  owna_in_if.sink   in_ch,
  owna_out_if.source out_ch
);
  import owna_pkg::*;

  localparam int unsigned LEN_W  = COORD_BITS + 2;
  localparam int unsigned PROD_W = TEMP_BITS + LEN_W;
  localparam int unsigned PER_W  = COORD_BITS + 2;
  localparam logic [ACC_W-1:0] TSIGN = ACC_W'(1) << (TEMP_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN, ST_MUL, ST_ACC, ST_FIN, ST_DIV, ST_OUT
  } state_t;

  state_t                     state;
  kind_t                      kind;
  logic                       last;
  logic        [COORD_BITS-1:0] bmin, bsize, nmin, nsize;
  logic signed [TEMP_BITS-1:0] temp;
  logic signed [LEN_W-1:0]     len;
  logic signed [PROD_W-1:0]    prod;
  logic        [PER_W-1:0]     per;
  logic        [ACC_W-1:0]     sum;
  logic                        neg;
  logic signed [TEMP_BITS-1:0] res;
  logic                        err;

  logic                        div_start;
  logic                        div_done;
  logic        [ACC_W-1:0]     div_quot;

  logic        [COORD_BITS:0]  bmax, nmax;
  logic        [LEN_W-1:0]     ovl;
  logic        [ACC_W-1:0]     mag;
  logic        [ACC_W-1:0]     q_sat;
  logic                        sat;
  logic                        load_out;

  // Four-case overlap rule on the edge chosen at capture.
  always_comb begin
    bmax = {1'b0, bmin} + {1'b0, bsize};
    nmax = {1'b0, nmin} + {1'b0, nsize};
    if (({1'b0, nmin} <= {1'b0, bmin}) && (nmax <= bmax)) begin
      ovl = {1'b0, nmax} - {2'b00, bmin};
    end else if (({1'b0, nmin} >= {1'b0, bmin}) && (nmax > bmax)) begin
      ovl = {1'b0, bmax} - {2'b00, nmin};
    end else if (({1'b0, nmin} < {1'b0, bmin}) && (nmax > bmax)) begin
      ovl = {2'b00, bsize};
    end else begin
      ovl = {2'b00, nsize};
    end
  end

  // Magnitude of the final sum for the divider.
  assign mag = sum[ACC_W-1] ? (ACC_W'(0) - sum) : sum;

  // Saturation of the quotient to the signed temperature range.
  always_comb begin
    if (neg) begin
      sat   = (div_quot > TSIGN);
      q_sat = sat ? TSIGN : div_quot;
    end else begin
      sat   = (div_quot > (TSIGN - ACC_W'(1)));
      q_sat = sat ? (TSIGN - ACC_W'(1)) : div_quot;
    end
  end

  assign div_start     = (state == ST_FIN) && (per != '0);
  assign in_ch.ready   = (state == ST_IDLE);
  assign load_out      = (state == ST_OUT) && (!out_ch.valid || out_ch.ready);

  owna_div #(
    .NUM_W(ACC_W),
    .DEN_W(PER_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (mag),
    .den  (per),
    .done (div_done),
    .quot (div_quot)
  );

  // Sequencer with the datapath registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sum          <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      // The output register takes a finished result once the previous one has gone.
      if (load_out) begin
        out_ch.valid      <= 1'b1;
        out_ch.border_avg <= res;
        out_ch.error_flag <= err;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            kind  <= in_ch.kind;
            last  <= in_ch.last;
            temp  <= in_ch.kind[1] ? in_ch.box_temp : in_ch.nbr_temp;
            bmin  <= in_ch.kind[0] ? in_ch.box_y : in_ch.box_x;
            bsize <= in_ch.kind[0] ? in_ch.box_height : in_ch.box_width;
            nmin  <= in_ch.kind[0] ? in_ch.nbr_y : in_ch.nbr_x;
            nsize <= in_ch.kind[0] ? in_ch.nbr_height : in_ch.nbr_width;
            per   <= {1'b0, in_ch.box_width, 1'b0} + {1'b0, in_ch.box_height, 1'b0};
            state <= ST_LEN;
          end
        end
        ST_LEN: begin
          // Empty sides weigh the cell's own temperature by the side length.
          if (kind == KIND_EMPTY_TB || kind == KIND_EMPTY_LR) begin
            len <= {2'b00, bsize};
          end else begin
            len <= ovl;
          end
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod  <= PROD_W'(temp) * PROD_W'(len);
          state <= ST_ACC;
        end
        ST_ACC: begin
          sum   <= sum + ACC_W'(prod);
          state <= last ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          neg <= sum[ACC_W-1];
          sum <= '0;
          if (per == '0) begin
            res   <= '0;
            err   <= 1'b1;
            state <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            res   <= neg ? TEMP_BITS'(ACC_W'(0) - q_sat) : TEMP_BITS'(q_sat);
            err   <= sat;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/owna_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none

module owna_div #(
  parameter int unsigned NUM_W = 64,
  parameter int unsigned DEN_W = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic      [NUM_W-1:0] quot
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [DEN_W:0]   shifted;
  logic             fits;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign shifted = {rem, quot[NUM_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  // Shift quotient bits in from the right while the dividend moves out at the left.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt  <= CNT_W'(NUM_W);
        rem  <= '0;
        dvs  <= den;
        quot <= num;
      end else if (cnt != '0) begin
        rem  <= fits ? DEN_W'(shifted - {1'b0, dvs}) : shifted[DEN_W-1:0];
        quot <= {quot[NUM_W-2:0], fits};
        cnt  <= cnt - CNT_W'(1);
        done <= (cnt == CNT_W'(1));
      end
    end
  end

endmodule

`default_nettype wire

[rtl/owna_chk.sv]
// Port-level checker for the overlap-weighted neighbor average block, bound to the top level.
`default_nettype none

module owna_chk #(
  parameter int unsigned TEMP_BITS = 32
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        in_last,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic signed [TEMP_BITS-1:0] border_avg,
  input wire logic                        error_flag
);

  localparam logic signed [TEMP_BITS-1:0] T_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
  localparam logic signed [TEMP_BITS-1:0] T_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Each accepted transaction occupies the block for the following cycles.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted before the previous transaction finished");

  // A flagged result is zero or one of the saturation bounds.
  a_err_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |->
      border_avg == '0 || border_avg == T_MAX || border_avg == T_MIN)
    else $error("error flag with an unsaturated value");

  // A contribution that does not close a cell yields no new result.
  a_no_result_mid_cell: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !in_last |=> ##3 !$rose(out_valid))
    else $error("result produced for a contribution without last");

endmodule

bind overlap_weighted_neighbor_average_core owna_chk #(
  .TEMP_BITS(TEMP_BITS)
) u_owna_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last      (in_ch.last),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .border_avg   (out_ch.border_avg),
  .error_flag   (out_ch.error_flag)
);

`default_nettype wire
